### design/mrsp_pkg.sv
// Shared types and constants for the MIDI running-status parser.
`default_nettype none
package mrsp_pkg;

   // Status byte boundaries.
   localparam logic [7:0] ST_NOTE_OFF = 8'h80;
   localparam logic [7:0] ST_SYSTEM   = 8'hF0;
   localparam logic [7:0] ST_REALTIME = 8'hF8;

   // Upper nibble of a channel status byte, bit 7 dropped.
   localparam logic [2:0] TYPE_NOTE_OFF   = 3'h0;
   localparam logic [2:0] TYPE_NOTE_ON    = 3'h1;
   localparam logic [2:0] TYPE_CC         = 3'h3;
   localparam logic [2:0] TYPE_PROGRAM    = 3'h4;
   localparam logic [2:0] TYPE_CHAN_PRESS = 3'h5;
   localparam logic [2:0] TYPE_BEND       = 3'h6;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_NOTE_OFF = 3'd0,
      KIND_NOTE_ON  = 3'd1,
      KIND_CC       = 3'd2,
      KIND_BEND     = 3'd3,
      KIND_PRESSURE = 3'd4,
      KIND_OTHER    = 3'd5
   } msg_kind_type;

   typedef enum logic [1:0] {
      CLS_SYSTEM = 2'd0,
      CLS_STATUS = 2'd1,
      CLS_DATA   = 2'd2
   } byte_class_type;

   typedef struct packed {
      byte_class_type cls;
      logic [6:0]     value;
   } entry_type;

endpackage
`default_nettype wire

### design/mrsp_front.sv
// Front end: accepts bytes, drops real-time bytes and classifies the rest.
`default_nettype none
module mrsp_front (
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               queue_full,
   output logic                    push,
   output mrsp_pkg::entry_type     push_entry
);
   import mrsp_pkg::*;

   logic accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Real-time bytes leave all state as is: take them and forward nothing.
   assign push = accept && (req_rx_byte < ST_REALTIME);

   always_comb begin
      push_entry.value = req_rx_byte[6:0];
      priority if (req_rx_byte >= ST_SYSTEM) begin
         push_entry.cls = CLS_SYSTEM;
      end else if (req_rx_byte >= ST_NOTE_OFF) begin
         push_entry.cls = CLS_STATUS;
      end else begin
         push_entry.cls = CLS_DATA;
      end
   end

endmodule
`default_nettype wire

### design/mrsp_queue.sv
// Short queue of classified bytes between the front end and the back end.
`default_nettype none
module mrsp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire mrsp_pkg::entry_type push_entry,
   input  wire logic                pop,
   output mrsp_pkg::entry_type      head_entry,
   output logic                     not_empty,
   output logic                     full
);
   import mrsp_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;

   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

### design/mrsp_back.sv
// Back end: running-status state, message assembly and the result register.
`default_nettype none
module mrsp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mrsp_pkg::entry_type head_entry,
   input  wire logic                head_valid,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_msg_kind,
   output logic [3:0]               rsp_channel,
   output logic [6:0]               rsp_first_data,
   output logic [6:0]               rsp_second_data
);
   import mrsp_pkg::*;

   logic         status_valid_ff, status_valid_in;
   logic [6:0]   status_ff,       status_in;
   logic         two_byte_ff,     two_byte_in;
   logic         seen_ff,         seen_in;
   logic [6:0]   held_ff,         held_in;

   logic         rsp_valid_ff, rsp_valid_in;
   msg_kind_type kind_ff, kind_in;
   logic [3:0]   channel_ff, channel_in;
   logic [6:0]   first_ff, first_in;
   logic [6:0]   second_ff, second_in;

   logic         out_free;
   logic         emit;
   logic [2:0]   stype;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = head_valid && out_free;
   assign stype    = status_ff[6:4];

   always_comb begin
      status_valid_in = status_valid_ff;
      status_in       = status_ff;
      two_byte_in     = two_byte_ff;
      seen_in         = seen_ff;
      held_in         = held_ff;
      emit            = 1'b0;
      first_in        = first_ff;
      second_in       = second_ff;
      channel_in      = channel_ff;
      kind_in         = kind_ff;

      if (pop) begin
         unique case (head_entry.cls)
            CLS_SYSTEM: begin
               status_valid_in = 1'b0;
               seen_in         = 1'b0;
            end
            CLS_STATUS: begin
               status_valid_in = 1'b1;
               status_in       = head_entry.value;
               two_byte_in     = !((head_entry.value[6:4] == TYPE_PROGRAM) ||
                                   (head_entry.value[6:4] == TYPE_CHAN_PRESS));
               seen_in         = 1'b0;
            end
            CLS_DATA: begin
               if (status_valid_ff) begin
                  if (two_byte_ff && !seen_ff) begin
                     held_in = head_entry.value;
                     seen_in = 1'b1;
                  end else begin
                     emit    = 1'b1;
                     seen_in = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (emit) begin
         channel_in = status_ff[3:0];
         if (two_byte_ff) begin
            first_in  = held_ff;
            second_in = head_entry.value;
         end else begin
            first_in  = head_entry.value;
            second_in = '0;
         end
         priority if (stype == TYPE_NOTE_ON) begin
            // Velocity zero means note off.
            kind_in = (head_entry.value == '0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
         end else if (stype == TYPE_NOTE_OFF) begin
            kind_in = KIND_NOTE_OFF;
         end else if (stype == TYPE_CC) begin
            kind_in = KIND_CC;
         end else if (stype == TYPE_BEND) begin
            kind_in = KIND_BEND;
         end else if (stype == TYPE_CHAN_PRESS) begin
            kind_in = KIND_PRESSURE;
         end else begin
            kind_in = KIND_OTHER;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_valid_ff <= 1'b0;
         status_ff       <= '0;
         two_byte_ff     <= 1'b0;
         seen_ff         <= 1'b0;
         held_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         status_valid_ff <= status_valid_in;
         status_ff       <= status_in;
         two_byte_ff     <= two_byte_in;
         seen_ff         <= seen_in;
         held_ff         <= held_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      channel_ff <= channel_in;
      first_ff   <= first_in;
      second_ff  <= second_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_msg_kind    = kind_ff;
   assign rsp_channel     = channel_ff;
   assign rsp_first_data  = first_ff;
   assign rsp_second_data = second_ff;

endmodule
`default_nettype wire

### design/midi_running_status_parser_core.sv
// Top level of the MIDI running-status parser.
`default_nettype none
// Takes one MIDI byte per transfer on req_ and returns decoded channel-voice
// messages on rsp_. Real-time bytes (0xF8-0xFF) are taken and ignored; system
// bytes (0xF0-0xF7) cancel the running status; a channel status byte sets the
// running status, and each complete group of one or two data bytes under it
// yields one message (note-on with velocity zero comes out as note off). Data
// bytes with no running status are dropped. Throughput is one byte per cycle
// while rsp_ready stays high. The byte that completes a message is written
// into the two-entry queue at its transfer edge, and the back end pops it and
// loads the result register once that register is free, from where the
// message shows on rsp_ until it transfers. The queue lets bytes keep flowing
// after the result side stalls, until it fills; req_ready drops only when the
// queue is full.
module midi_running_status_parser_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_msg_kind,
   output logic [3:0]      rsp_channel,
   output logic [6:0]      rsp_first_data,
   output logic [6:0]      rsp_second_data
);
   import mrsp_pkg::*;

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_not_empty;
   entry_type     push_entry;
   entry_type     head_entry;

   // Classify incoming bytes and drop real-time ones.
   mrsp_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .queue_full  (q_full),
      .push        (q_push),
      .push_entry  (push_entry)
   );

   // Hold classified bytes so either side may stall on its own.
   mrsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   // Track the running status and assemble messages.
   mrsp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .head_valid      (q_not_empty),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_msg_kind    (rsp_msg_kind),
      .rsp_channel     (rsp_channel),
      .rsp_first_data  (rsp_first_data),
      .rsp_second_data (rsp_second_data)
   );

endmodule
`default_nettype wire

### verif/midi_running_status_parser_core_tb.sv
// Self-checking testbench for the MIDI running-status parser core.
`timescale 1ns / 100ps

module midi_running_status_parser_core_tb;
   import mrsp_pkg::*;

   // One decoded channel-voice message as it should leave the rsp_ channel.
   typedef struct packed {
      msg_kind_type kind;
      logic [3:0]   channel;
      logic [6:0]   first_data;
      logic [6:0]   second_data;
   } midi_msg_type;

   // One row of the directed table: the byte to send and, where the result
   // is obvious, the message it must produce (typed=1), else predicted.
   typedef struct packed {
      logic [7:0]   rx_byte;
      bit           typed;
      bit           has_msg;
      midi_msg_type msg;
   } byte_row_type;

   localparam int unsigned NUM_ROWS       = 26;
   localparam int unsigned ITEMS_PER_PASS = 350;
   localparam int unsigned RSP_HOLD       = 300;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned WATCHDOG_LIMIT = 5000;

   logic       clock;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte     = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic [2:0] rsp_msg_kind;
   logic [3:0] rsp_channel;
   logic [6:0] rsp_first_data;
   logic [6:0] rsp_second_data;

   // Shaping knobs, set by the stimulus process and read by the others.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct  = 0;
   bit          rsp_hold_req  = 1'b0;

   int unsigned error_count   = 0;
   int unsigned counted_bytes = 0;

   // Messages predicted but not yet seen on rsp_, oldest first.
   midi_msg_type pending_msgs[$];
   midi_msg_type oldest_msg;

   // Shadow parser state.
   logic [7:0]  run_status;
   logic [1:0]  data_len;
   logic [1:0]  seen_data;
   logic [6:0]  held_first;

   byte_row_type byte_rows [0:NUM_ROWS-1];

   midi_running_status_parser_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_msg_kind    (rsp_msg_kind),
      .rsp_channel     (rsp_channel),
      .rsp_first_data  (rsp_first_data),
      .rsp_second_data (rsp_second_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Program change and channel pressure carry one data byte, the rest two.
   function automatic logic [1:0] data_len_of(input logic [7:0] status);
      if (status[6:4] == TYPE_PROGRAM || status[6:4] == TYPE_CHAN_PRESS)
         return 2'd1;
      return 2'd2;
   endfunction

   // Bias data toward the extremes so that zero velocity shows up often.
   function automatic logic [6:0] pick_data();
      case ($urandom_range(7))
         0: return 7'd0;
         1: return 7'd127;
         default: return 7'($urandom_range(127));
      endcase
   endfunction

   function automatic byte_row_type byte_row(input logic [7:0] rx, input bit typed,
                                             input bit has_msg, input msg_kind_type kind,
                                             input logic [3:0] channel, input logic [6:0] d1,
                                             input logic [6:0] d2);
      byte_row_type row;
      row.rx_byte          = rx;
      row.typed            = typed;
      row.has_msg          = has_msg;
      row.msg.kind         = kind;
      row.msg.channel      = channel;
      row.msg.first_data   = d1;
      row.msg.second_data  = d2;
      return row;
   endfunction

   // Advance the shadow parser by one byte and return the message it completes.
   task automatic decode_byte(input logic [7:0] b, output bit has_msg,
                              output midi_msg_type m);
      logic [6:0] d1;
      logic [6:0] d2;
      has_msg = 1'b0;
      m       = '0;
      if (b >= ST_REALTIME) begin
         // Real-time bytes slip through without touching any state.
      end else if (b >= ST_SYSTEM) begin
         // System common and SysEx cancel the running status.
         run_status = 8'h00;
         seen_data  = 2'd0;
      end else if (b >= ST_NOTE_OFF) begin
         // New channel status: drop any partial message and restart.
         run_status = b;
         data_len   = data_len_of(b);
         seen_data  = 2'd0;
      end else if (run_status == 8'h00) begin
         // Orphan data byte: drop it.
      end else if (data_len == 2'd2 && seen_data == 2'd0) begin
         held_first = b[6:0];
         seen_data  = 2'd1;
      end else begin
         if (data_len == 2'd2) begin
            d1 = held_first;
            d2 = b[6:0];
         end else begin
            d1 = b[6:0];
            d2 = 7'd0;
         end
         seen_data = 2'd0;
         case (run_status[6:4])
            TYPE_NOTE_ON: begin
               // Zero velocity means note off.
               if (data_len == 2'd2 && d2 == 7'd0)
                  m.kind = KIND_NOTE_OFF;
               else
                  m.kind = KIND_NOTE_ON;
            end
            TYPE_NOTE_OFF:   m.kind = KIND_NOTE_OFF;
            TYPE_CC:         m.kind = KIND_CC;
            TYPE_BEND:       m.kind = KIND_BEND;
            TYPE_CHAN_PRESS: m.kind = KIND_PRESSURE;
            default:         m.kind = KIND_OTHER;
         endcase
         m.channel     = run_status[3:0];
         m.first_data  = d1;
         m.second_data = d2;
         has_msg       = 1'b1;
      end
   endtask

   // Offer one byte on req_ after a random gap, hold it until the transfer,
   // then record the message it produces. Called at a rising edge; returns at
   // the edge of the transfer with req_valid still high.
   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input bit typed_has = 1'b0,
                            input midi_msg_type typed_msg = '0);
      bit           has_msg;
      midi_msg_type m;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b, has_msg, m);
      // Typed rows override the prediction; the shadow state still advances.
      if (typed) begin
         has_msg = typed_has;
         m       = typed_msg;
      end
      if (has_msg)
         pending_msgs.push_back(m);
      if (b < ST_REALTIME)
         counted_bytes++;
   endtask

   // Send a data byte, now and then with a real-time byte slipped in ahead.
   task automatic send_data(input logic [6:0] d);
      if ($urandom_range(11) == 0)
         send_byte(8'($urandom_range(255, 248)));
      send_byte({1'b0, d});
   endtask

   // Drop valid and hold the sender until every predicted message is out.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_msgs.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed running-status streams with random content; the rest
   // are cut-short messages and raw noise across the whole byte range.
   task automatic send_random_traffic(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned groups;
      logic [7:0]  status;
      stop_at = counted_bytes + count;
      while (counted_bytes < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            status = {1'b1, 3'($urandom_range(6)), 4'($urandom_range(15))};
            send_byte(status);
            groups = $urandom_range(4, 1);
            for (int unsigned g = 0; g < groups; g++) begin
               // Repeat the status now and then instead of relying on running status.
               if (g != 0 && $urandom_range(5) == 0)
                  send_byte(status);
               for (int unsigned k = 0; k < data_len_of(status); k++)
                  send_data(pick_data());
            end
         end else if (pick < 88) begin
            // Cut a message short with a new status or a system byte.
            status = {1'b1, 3'($urandom_range(6)), 4'($urandom_range(15))};
            send_byte(status);
            if ($urandom_range(1) == 1)
               send_data(pick_data());
            if ($urandom_range(1) == 1)
               send_byte(8'($urandom_range(247, 240)));
            else
               send_byte({1'b1, 3'($urandom_range(6)), 4'($urandom_range(15))});
         end else begin
            for (int unsigned k = $urandom_range(3, 1); k > 0; k--)
               send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   // Receiver: idle at the set rate; on request, hold off for a long stretch
   // so that the queue fills and req_ready drops.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            for (int unsigned k = 0; k < RSP_HOLD; k++) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         @(posedge clock);
      end
   end

   // Compare each message transfer with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_msgs.size() == 0) begin
            $display("%0t: unexpected message: expected none, actual kind %0d ch %0d %0d %0d",
                     $time, rsp_msg_kind, rsp_channel, rsp_first_data, rsp_second_data);
            error_count++;
         end else begin
            oldest_msg = pending_msgs.pop_front();
            if (rsp_msg_kind !== oldest_msg.kind) begin
               $display("%0t: msg_kind mismatch: expected %0d, actual %0d",
                        $time, oldest_msg.kind, rsp_msg_kind);
               error_count++;
            end
            if (rsp_channel !== oldest_msg.channel) begin
               $display("%0t: channel mismatch: expected %0d, actual %0d",
                        $time, oldest_msg.channel, rsp_channel);
               error_count++;
            end
            if (rsp_first_data !== oldest_msg.first_data) begin
               $display("%0t: first_data mismatch: expected %0d, actual %0d",
                        $time, oldest_msg.first_data, rsp_first_data);
               error_count++;
            end
            if (rsp_second_data !== oldest_msg.second_data) begin
               $display("%0t: second_data mismatch: expected %0d, actual %0d",
                        $time, oldest_msg.second_data, rsp_second_data);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens on either side for too long.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: watchdog expired with %0d messages outstanding",
               $time, pending_msgs.size());
      $display("TB_ERROR");
      $finish;
   end

   // Main stimulus.
   initial begin
      // Directed table: running status, zero velocity, real-time bytes in the
      // middle of a message, one-byte kinds, status change mid-message,
      // SysEx end, orphan data.
      byte_rows[0]  = byte_row(8'h90, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[1]  = byte_row(8'h00, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[2]  = byte_row(8'h7F, 1, 1, KIND_NOTE_ON,  4'd0,  7'd0,   7'd127);
      byte_rows[3]  = byte_row(8'h3C, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[4]  = byte_row(8'h00, 1, 1, KIND_NOTE_OFF, 4'd0,  7'd60,  7'd0);
      byte_rows[5]  = byte_row(8'h8F, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[6]  = byte_row(8'h7F, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[7]  = byte_row(8'hFF, 1, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[8]  = byte_row(8'h7F, 1, 1, KIND_NOTE_OFF, 4'd15, 7'd127, 7'd127);
      byte_rows[9]  = byte_row(8'hA5, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[10] = byte_row(8'h11, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[11] = byte_row(8'h22, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[12] = byte_row(8'hC0, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[13] = byte_row(8'h05, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[14] = byte_row(8'hDF, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[15] = byte_row(8'h7F, 1, 1, KIND_PRESSURE, 4'd15, 7'd127, 7'd0);
      byte_rows[16] = byte_row(8'hEF, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[17] = byte_row(8'h00, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[18] = byte_row(8'h40, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[19] = byte_row(8'h90, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[20] = byte_row(8'h10, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[21] = byte_row(8'hB1, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[22] = byte_row(8'h01, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[23] = byte_row(8'h02, 0, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[24] = byte_row(8'hF7, 1, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);
      byte_rows[25] = byte_row(8'h12, 1, 0, KIND_NOTE_OFF, 4'd0,  7'd0,   7'd0);

      // Shadow state starts where reset leaves the block.
      run_status = 8'h00;
      data_len   = 2'd0;
      seen_data  = 2'd0;
      held_first = 7'd0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pass one: slow receiver, mostly busy sender.
      send_idle_pct = 27;
      rsp_idle_pct  = 80;
      for (int unsigned i = 0; i < NUM_ROWS; i++)
         send_byte(byte_rows[i].rx_byte, byte_rows[i].typed,
                   byte_rows[i].has_msg, byte_rows[i].msg);
      send_random_traffic(ITEMS_PER_PASS);
      wait_for_drain();

      // Pass two: roles swapped.
      send_idle_pct = 80;
      rsp_idle_pct  = 27;
      send_random_traffic(ITEMS_PER_PASS);
      wait_for_drain();

      // Pass three: full rate, with one long receiver hold-off up front.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      rsp_hold_req  = 1'b1;
      send_random_traffic(ITEMS_PER_PASS);
      wait_for_drain();

      // Let the pipeline settle; any late extra message is caught by the monitor.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_msgs.size() != 0) begin
         $display("%0t: %0d expected messages never arrived", $time, pending_msgs.size());
         error_count++;
      end

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
